>>> sv/fastq_record_framer_defines.svh
// Assertion macros shared by the fastq record framer RTL
`ifndef FASTQ_RECORD_FRAMER_DEFINES_SVH
`define FASTQ_RECORD_FRAMER_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define FQF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define FQF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fqf_pkg.sv
// Package with types and constants of the fastq record framer
`timescale 1ns / 1ps
package fqf_pkg;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] FIELD16_MAX = 16'hFFFF;
  localparam logic [17:0] FIELD18_MAX = 18'h3FFFF;

  localparam int OUT_TDATA_W = 120;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_START = 2'd1,
    STAT_MISMATCH  = 2'd2,
    STAT_TRUNC     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_REC     = 3'b010,
    ST_DISCARD = 3'b100
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] id_line_len;
    logic [15:0] seq_line_len;
    logic [15:0] plus_line_len;
    logic [15:0] qual_line_len;
    logic [17:0] record_len;
    logic [15:0] tag_offset;
    logic [15:0] tag_len;
  } res_t;

endpackage

>>> sv/fqf_parser.sv
// Record parser: per-byte state update and result formation
`timescale 1ns / 1ps
`include "fastq_record_framer_defines.svh"
module fqf_parser #(
  parameter int LEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                res_valid,
  output fqf_pkg::res_t       res
);

  localparam int AW = LEN_BITS + 2;
  localparam int XW = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam int TW = (AW > 18) ? AW : 18;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  fqf_pkg::state_t       state_r, state_nxt;
  logic [1:0]            line_idx_r, line_idx_nxt;
  logic [LEN_BITS-1:0]   line_cnt_r, line_cnt_nxt;
  logic [LEN_BITS-1:0]   len_r [3];
  logic [LEN_BITS-1:0]   len_nxt [3];
  logic [AW-1:0]         acc_r, acc_nxt;
  logic                  dot_seen_r, dot_seen_nxt;
  logic [LEN_BITS-1:0]   dot_off_r, dot_off_nxt;
  logic [LEN_BITS-1:0]   dot_len_r, dot_len_nxt;
  logic                  dot_closed_r, dot_closed_nxt;
  logic [LEN_BITS-1:0]   at_len_r, at_len_nxt;
  logic                  at_closed_r, at_closed_nxt;

  logic                  clr;
  logic                  start;
  logic [LEN_BITS-1:0]   lc_inc;
  logic [AW-1:0]         total;
  logic [TW-1:0]         total_ext;
  logic                  mismatch;
  logic                  is_nl;
  logic                  is_sp;

  function automatic logic [15:0] clip16(input logic [LEN_BITS-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    return (e > XW'(fqf_pkg::FIELD16_MAX)) ? fqf_pkg::FIELD16_MAX : e[15:0];
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  assign lc_inc    = sat_inc(line_cnt_r);
  assign total     = acc_r + AW'(lc_inc);
  assign total_ext = TW'(total);
  assign mismatch  = (lc_inc != len_r[1]);
  assign is_nl     = (in_byte == fqf_pkg::CH_NL);
  assign is_sp     = (in_byte == fqf_pkg::CH_SPACE);

  always_comb begin
    state_nxt      = state_r;
    line_idx_nxt   = line_idx_r;
    line_cnt_nxt   = line_cnt_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    dot_seen_nxt   = dot_seen_r;
    dot_off_nxt    = dot_off_r;
    dot_len_nxt    = dot_len_r;
    dot_closed_nxt = dot_closed_r;
    at_len_nxt     = at_len_r;
    at_closed_nxt  = at_closed_r;
    clr            = 1'b0;
    start          = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    if (adv) begin
      unique case (state_r)
        fqf_pkg::ST_DISCARD: begin
          if (in_last) begin
            state_nxt = fqf_pkg::ST_IDLE;
          end
        end
        fqf_pkg::ST_IDLE: begin
          clr = 1'b1;
          if (in_byte != fqf_pkg::CH_AT) begin
            res_valid  = 1'b1;
            res.status = fqf_pkg::STAT_BAD_START;
            state_nxt  = in_last ? fqf_pkg::ST_IDLE : fqf_pkg::ST_DISCARD;
          end else if (in_last) begin
            res_valid  = 1'b1;
            res.status = fqf_pkg::STAT_TRUNC;
          end else begin
            start     = 1'b1;
            state_nxt = fqf_pkg::ST_REC;
          end
        end
        fqf_pkg::ST_REC: begin
          if (line_idx_r == 2'd0) begin
            if (is_nl || is_sp) begin
              at_closed_nxt = 1'b1;
              if (dot_seen_r) begin
                dot_closed_nxt = 1'b1;
              end
            end else begin
              if (!at_closed_r) begin
                at_len_nxt = sat_inc(at_len_r);
              end
              if (dot_seen_r) begin
                if (!dot_closed_r) begin
                  dot_len_nxt = sat_inc(dot_len_r);
                end
              end else if (in_byte == fqf_pkg::CH_DOT) begin
                dot_seen_nxt = 1'b1;
                dot_off_nxt  = lc_inc;
                dot_len_nxt  = '0;
              end
            end
          end
          line_cnt_nxt = lc_inc;
          if (is_nl && line_idx_r == 2'd3) begin
            res_valid         = 1'b1;
            res.status        = mismatch ? fqf_pkg::STAT_MISMATCH : fqf_pkg::STAT_OK;
            res.id_line_len   = clip16(len_r[0]);
            res.seq_line_len  = clip16(len_r[1]);
            res.plus_line_len = clip16(len_r[2]);
            res.qual_line_len = clip16(lc_inc);
            res.record_len    = (total_ext > TW'(fqf_pkg::FIELD18_MAX)) ?
                                fqf_pkg::FIELD18_MAX : total_ext[17:0];
            res.tag_offset    = dot_seen_r ? clip16(dot_off_r) : 16'd1;
            res.tag_len       = dot_seen_r ? clip16(dot_len_r) : clip16(at_len_r);
            clr               = 1'b1;
            state_nxt         = (mismatch && !in_last) ? fqf_pkg::ST_DISCARD :
                                fqf_pkg::ST_IDLE;
          end else begin
            if (is_nl) begin
              len_nxt[line_idx_r] = lc_inc;
              acc_nxt             = acc_r + AW'(lc_inc);
              line_idx_nxt        = line_idx_r + 2'd1;
              line_cnt_nxt        = '0;
            end
            if (in_last) begin
              res_valid  = 1'b1;
              res.status = fqf_pkg::STAT_TRUNC;
              clr        = 1'b1;
              state_nxt  = fqf_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state_nxt = fqf_pkg::ST_IDLE;
        end
      endcase
    end
    if (clr) begin
      line_idx_nxt   = '0;
      line_cnt_nxt   = start ? LEN_BITS'(1) : '0;
      len_nxt[0]     = '0;
      len_nxt[1]     = '0;
      len_nxt[2]     = '0;
      acc_nxt        = '0;
      dot_seen_nxt   = 1'b0;
      dot_off_nxt    = '0;
      dot_len_nxt    = '0;
      dot_closed_nxt = 1'b0;
      at_len_nxt     = '0;
      at_closed_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fqf_pkg::ST_IDLE;
      line_idx_r   <= '0;
      line_cnt_r   <= '0;
      len_r[0]     <= '0;
      len_r[1]     <= '0;
      len_r[2]     <= '0;
      acc_r        <= '0;
      dot_seen_r   <= 1'b0;
      dot_off_r    <= '0;
      dot_len_r    <= '0;
      dot_closed_r <= 1'b0;
      at_len_r     <= '0;
      at_closed_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_idx_r   <= line_idx_nxt;
      line_cnt_r   <= line_cnt_nxt;
      len_r        <= len_nxt;
      acc_r        <= acc_nxt;
      dot_seen_r   <= dot_seen_nxt;
      dot_off_r    <= dot_off_nxt;
      dot_len_r    <= dot_len_nxt;
      dot_closed_r <= dot_closed_nxt;
      at_len_r     <= at_len_nxt;
      at_closed_r  <= at_closed_nxt;
    end
  end

  `FQF_ASSERT_NOW(a_discard_silent, adv && state_r == fqf_pkg::ST_DISCARD, !res_valid, "result while discarding")
  `FQF_ASSERT_NOW(a_ok_lengths, res_valid && res.status == fqf_pkg::STAT_OK, res.seq_line_len == res.qual_line_len, "ok record with unequal lengths")
  `FQF_ASSERT_NOW(a_line_in_rec, line_idx_r != 2'd0, state_r == fqf_pkg::ST_REC, "line index set outside a record")
  `FQF_ASSERT_NEXT(a_bad_start_drop, adv && state_r == fqf_pkg::ST_IDLE && in_byte != fqf_pkg::CH_AT && !in_last, state_r == fqf_pkg::ST_DISCARD, "bad start did not enter discard")

endmodule

>>> sv/fqf_out_reg.sv
// Result register holding one item for the output channel
`timescale 1ns / 1ps
module fqf_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  fqf_pkg::res_t res,
  input  logic          out_tready,
  output logic          out_valid,
  output fqf_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  fqf_pkg::res_t res_r;

  assign valid_nxt = res_valid || (valid_r && !out_tready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

>>> sv/fastq_record_framer.sv
// Top level of the fastq record framer
//
// Input channel in_*: one text byte per item in in_tdata, in_tlast marks the
// final byte of a buffer. Output channel out_*: one item per finished record
// (fourth newline), per bad start character, or per record cut short by
// in_tlast; out_tuser carries the status, out_tdata the line lengths, the
// total length and the identifier tag position.
// A result appears on out_tvalid once its closing byte has been accepted
// and has passed the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls; every byte passes
// one input register and a single pass of counter and compare logic.
// Stall: while an unread result waits, the parser holds the byte in the
// input register and in_tready drops; the input register still takes a byte
// when it is empty, and everything moves on the cycle out_tready rises.
// Reset: rst_n low clears both registers' valid flags and the parser, which
// then waits for the '@' that opens a record.
`timescale 1ns / 1ps
module fastq_record_framer #(
  parameter int LEN_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] data_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] id_line_len, [31:16] seq_line_len, [47:32] plus_line_len,
  // [63:48] qual_line_len, [81:64] record_len, [97:82] tag_offset,
  // [113:98] tag_len, [119:114] zero
  output logic [fqf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                         out_tuser  // [1:0] status
);

  logic          in_vld_r, in_vld_nxt;
  logic [7:0]    in_byte_r;
  logic          in_last_r;
  logic          adv;
  logic          in_acc;
  logic          res_valid;
  fqf_pkg::res_t res;
  fqf_pkg::res_t out_res;

  assign adv        = in_vld_r && (!out_tvalid || out_tready);
  assign in_tready  = !in_vld_r || adv;
  assign in_acc     = in_tvalid && in_tready;
  assign in_vld_nxt = in_acc || (in_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  fqf_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_byte   (in_byte_r),
    .in_last   (in_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  fqf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {6'd0, out_res.tag_len, out_res.tag_offset, out_res.record_len,
                      out_res.qual_line_len, out_res.plus_line_len,
                      out_res.seq_line_len, out_res.id_line_len};

endmodule
